>>> rtl/core/pcmu_pkg.sv
package pcmu_pkg;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_SAMPLE_BYTES   = 3'd0;
  localparam reg_idx_t REG_CHANNEL_COUNT  = 3'd1;
  localparam reg_idx_t REG_BIG_ENDIAN     = 3'd2;
  localparam reg_idx_t REG_LENGTH_LIMITED = 3'd3;
  localparam reg_idx_t REG_AUDIO_LENGTH   = 3'd4;

  localparam logic [2:0] SAMPLE_BYTES_RESET  = 3'd2;
  localparam logic [1:0] CHANNEL_COUNT_RESET = 2'd2;
  localparam logic [1:0] CHANNEL_COUNT_MONO  = 2'd1;

  localparam int unsigned ADDR_W = 5;

endpackage

>>> rtl/core/pcm_byte_to_sample_unpacker.sv
// pcm byte to sample unpacker
//
// in channel (in_valid/in_ready, stream_byte): one raw pcm stream byte per transfer.
// out channel (out_valid/out_ready, sample_word, channel, last): one sample word,
// left-justified in 32 bits, with its channel tag; last marks the final result
// caused by one input byte.
// the apb port sets sample size, channel count, byte order and the length limit;
// writing audio_length also reloads the remaining byte budget.
//
// a byte that completes a sample is registered into the output stage and shows
// on the out channel in the cycle after its transfer. the input takes one byte
// per cycle; a byte that does not complete a sample, or is dropped by the
// length limit, is taken even while the output stalls. a completing byte waits
// only while the output register is full and not draining. in mono mode the
// output register holds the sample for two transfers (left, then right), so a
// completing byte right behind it waits until the left transfer has gone.
// reset (rst, synchronous) restores the register defaults and clears the
// partial sample, byte position, channel tag, budget and the output valid flags.
module pcm_byte_to_sample_unpacker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [pcmu_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] sample_word,
  output logic        channel,
  output logic        last
);

  logic [2:0]  sample_bytes;
  logic [1:0]  channel_count;
  logic        big_endian;
  logic        length_limited;
  logic [31:0] audio_length;

  logic [23:0] partial;
  logic [23:0] partial_next;
  logic [31:0] partial_wide;
  logic [1:0]  byte_position;
  logic        channel_index;
  logic [31:0] remaining_bytes;
  logic        out_dup;

  logic                 cfg_write;
  pcmu_pkg::reg_idx_t   cfg_idx;
  logic [2:0]  n;
  logic [2:0]  n_m1;
  logic        mono;
  logic [1:0]  pos;
  logic [3:0]  bpf;
  logic [3:0]  used;
  logic [3:0]  needed;
  logic        dropped;
  logic        is_final;
  logic        produces;
  logic        slot_free;
  logic        in_fire;
  logic        out_fire;
  logic        take;
  logic [31:0] word;
  logic [7:0]  lane_byte;
  logic [1:0]  lane;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = paddr[pcmu_pkg::ADDR_W-1:2];

  always_comb begin
    unique case (cfg_idx)
      pcmu_pkg::REG_SAMPLE_BYTES:   prdata = {29'd0, sample_bytes};
      pcmu_pkg::REG_CHANNEL_COUNT:  prdata = {30'd0, channel_count};
      pcmu_pkg::REG_BIG_ENDIAN:     prdata = {31'd0, big_endian};
      pcmu_pkg::REG_LENGTH_LIMITED: prdata = {31'd0, length_limited};
      pcmu_pkg::REG_AUDIO_LENGTH:   prdata = audio_length;
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_bytes   <= pcmu_pkg::SAMPLE_BYTES_RESET;
      channel_count  <= pcmu_pkg::CHANNEL_COUNT_RESET;
      big_endian     <= 1'b0;
      length_limited <= 1'b0;
      audio_length   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        pcmu_pkg::REG_SAMPLE_BYTES:   sample_bytes   <= pwdata[2:0];
        pcmu_pkg::REG_CHANNEL_COUNT:  channel_count  <= pwdata[1:0];
        pcmu_pkg::REG_BIG_ENDIAN:     big_endian     <= pwdata[0];
        pcmu_pkg::REG_LENGTH_LIMITED: length_limited <= pwdata[0];
        pcmu_pkg::REG_AUDIO_LENGTH:   audio_length   <= pwdata;
        default: ;
      endcase
    end
  end

  // effective sample size, frame bookkeeping and length check
  always_comb begin
    if (sample_bytes == 3'd0) begin
      n = 3'd1;
    end else if (sample_bytes > 3'd4) begin
      n = 3'd4;
    end else begin
      n = sample_bytes;
    end
    n_m1     = n - 3'd1;
    mono     = (channel_count == pcmu_pkg::CHANNEL_COUNT_MONO);
    pos      = ({1'b0, byte_position} > n_m1) ? n_m1[1:0] : byte_position;
    bpf      = mono ? {1'b0, n} : {n, 1'b0};
    used     = ((mono || !channel_index) ? 4'd0 : {1'b0, n}) + {2'd0, pos};
    needed   = bpf - used;
    dropped  = length_limited && (remaining_bytes < {28'd0, needed});
    is_final = (pos == n_m1[1:0]);
    produces = !dropped && is_final;
  end

  assign out_fire  = out_valid && out_ready;
  assign slot_free = !out_valid || (out_ready && !out_dup);
  assign in_ready  = !produces || slot_free;
  assign in_fire   = in_valid && in_ready;
  assign take      = in_fire && !dropped;

  assign partial_wide = {8'd0, partial};

  // assemble the sample, left-justified
  always_comb begin
    word      = '0;
    lane_byte = '0;
    lane      = '0;
    for (int k = 0; k < 4; k++) begin
      if (k < int'(n)) begin
        lane_byte = (k == int'(n_m1)) ? stream_byte : partial_wide[8*k +: 8];
        lane      = big_endian ? 2'(3 - k) : 2'(k + 4 - int'(n));
        word[{lane, 3'b000} +: 8] = lane_byte;
      end
    end
  end

  always_comb begin
    partial_next = partial;
    case (pos)
      2'd0:    partial_next[7:0]   = partial[7:0]   | stream_byte;
      2'd1:    partial_next[15:8]  = partial[15:8]  | stream_byte;
      2'd2:    partial_next[23:16] = partial[23:16] | stream_byte;
      default: partial_next = partial;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial       <= '0;
      byte_position <= '0;
      channel_index <= 1'b0;
    end else if (take) begin
      if (is_final) begin
        partial       <= '0;
        byte_position <= '0;
        channel_index <= mono ? 1'b0 : !channel_index;
      end else begin
        partial       <= partial_next;
        byte_position <= pos + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining_bytes <= '0;
    end else if (cfg_write && cfg_idx == pcmu_pkg::REG_AUDIO_LENGTH) begin
      remaining_bytes <= pwdata;
    end else if (take && length_limited) begin
      remaining_bytes <= remaining_bytes - 32'd1;
    end
  end

  // output stage; in mono the held word goes out twice
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_dup   <= 1'b0;
    end else if (take && is_final) begin
      out_valid <= 1'b1;
      out_dup   <= mono;
    end else if (out_fire) begin
      out_valid <= out_dup;
      out_dup   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && is_final) begin
      sample_word <= word;
      channel     <= mono ? 1'b0 : channel_index;
      last        <= !mono;
    end else if (out_fire && out_dup) begin
      channel <= 1'b1;
      last    <= 1'b1;
    end
  end

  a_dup_left_first: assert property (@(posedge clk) disable iff (rst)
    out_dup |-> out_valid && !channel && !last)
    else $error("mono duplicate pending without left result");

  a_dup_second: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_dup |=> out_valid && channel && last)
    else $error("mono right result missing");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && produces |=> out_valid)
    else $error("completed sample not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && produces |-> !out_valid || (out_ready && !out_dup))
    else $error("output stage overwritten");

endmodule
